// ===== design/pwa_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PNG pixel write addresser package
// Shared types and constants: request/response payloads, register indexes,
// colour kinds and the queue entry passed between front and back ends.
// ----------------------------------------------------------------------------
package pwa_pkg;

   // Address and queue geometry
   localparam int ADDR_BITS   = 35;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int QCOUNT_BITS = 3;

   // Configuration register indexes
   localparam logic [2:0] CSR_IMAGE_WIDTH  = 3'd0;
   localparam logic [2:0] CSR_IMAGE_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_SAMPLE_DEPTH = 3'd2;
   localparam logic [2:0] CSR_COLOUR_KIND  = 3'd3;
   localparam logic [2:0] CSR_MIRROR_X     = 3'd4;
   localparam logic [2:0] CSR_MIRROR_Y     = 3'd5;

   // PNG colour types
   localparam logic [2:0] KIND_GREY       = 3'd0;
   localparam logic [2:0] KIND_RGB        = 3'd2;
   localparam logic [2:0] KIND_PALETTE    = 3'd3;
   localparam logic [2:0] KIND_GREY_ALPHA = 3'd4;
   localparam logic [2:0] KIND_RGBA       = 3'd6;

   typedef struct packed {
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [63:0] pixel_value;
   } pwa_req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] byte_address;
      logic [7:0]           write_byte;
      logic [7:0]           write_mask;
      logic                 fault;
      logic                 last_write;
   } pwa_rsp_type;

   typedef struct packed {
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [4:0]  sample_depth;
      logic [2:0]  colour_kind;
      logic        mirror_x;
      logic        mirror_y;
   } pwa_cfg_type;

   // One classified pixel: first address, data bytes, mask and byte count
   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic [63:0]          value;
      logic [7:0]           mask;
      logic [3:0]           count;
      logic                 fault;
   } pwa_entry_type;

endpackage
`default_nettype wire

// ===== design/png_pixel_write_addresser_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PNG pixel write addresser core
// Turns pixel coordinates and colours into masked byte writes into a PNG
// raw buffer with one filter byte per scanline.
// ----------------------------------------------------------------------------
// A pixel is taken on start while busy is low, and up to one pixel per cycle
// is taken. Its first write passes through the stage-one register, the queue
// and the output register to rsp_strobe; the receiver cannot stall it.
// Sub-byte depths and errors give one write per pixel; 8 and 16 bit depths
// give bytes-per-pixel writes on consecutive cycles, so output bandwidth (one
// byte per cycle) sets the sustained pixel rate. busy rises while four pixels
// are in flight between the address stage, the queue and the output sequencer.
// The registers take effect for the next pixel; the user must write them only
// while idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module png_pixel_write_addresser_core
   import pwa_pkg::*;
#(
   parameter int DIM_BITS        = 16,
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   output logic               busy,
   input  wire pwa_req_type   req_data,
   output logic               rsp_strobe,
   output pwa_rsp_type        rsp_data,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [15:0]   csr_data
);

   pwa_cfg_type            cfg_ff, cfg_in;
   logic [QCOUNT_BITS-1:0] credit_ff, credit_in;
   logic                   accept, csr_write;
   logic                   q_push, q_pop, q_empty;
   pwa_entry_type          q_wdata, q_head;

   // Register writes
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  cfg_in.image_width  = csr_data;
            CSR_IMAGE_HEIGHT: cfg_in.image_height = csr_data;
            CSR_SAMPLE_DEPTH: cfg_in.sample_depth = csr_data[4:0];
            CSR_COLOUR_KIND:  cfg_in.colour_kind  = csr_data[2:0];
            CSR_MIRROR_X:     cfg_in.mirror_x     = csr_data[0];
            CSR_MIRROR_Y:     cfg_in.mirror_y     = csr_data[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.image_width  <= 16'd1;
         cfg_ff.image_height <= 16'd1;
         cfg_ff.sample_depth <= 5'd8;
         cfg_ff.colour_kind  <= KIND_GREY;
         cfg_ff.mirror_x     <= 1'b0;
         cfg_ff.mirror_y     <= 1'b1;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Track pixels in flight; hold off start when the queue could overflow
   assign accept    = start && !busy;
   assign busy      = (credit_ff == QCOUNT_BITS'(QUEUE_DEPTH));
   assign credit_in = credit_ff + QCOUNT_BITS'(accept) - QCOUNT_BITS'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   pwa_front #(
      .DIM_BITS        (DIM_BITS),
      .MAX_PIXEL_BYTES (MAX_PIXEL_BYTES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req_data  (req_data),
      .cfg       (cfg_ff),
      .out_valid (q_push),
      .out_entry (q_wdata)
   );

   pwa_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_head),
      .empty (q_empty)
   );

   pwa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .empty      (q_empty),
      .head       (q_head),
      .pop        (q_pop),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

// ===== design/pwa_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PNG pixel write addresser front end
// Classifies each accepted pixel (range, format, depth), mirrors the
// coordinate, forms the row stride and column offset, then multiplies out
// the first byte address for the queue.
// ----------------------------------------------------------------------------
module pwa_front
   import pwa_pkg::*;
#(
   parameter int DIM_BITS        = 16,
   parameter int MAX_PIXEL_BYTES = 8
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire pwa_req_type   req_data,
   input  wire pwa_cfg_type   cfg,
   output logic               out_valid,
   output pwa_entry_type      out_entry
);

   localparam logic [15:0] DIM_MASK =
      (DIM_BITS >= 16) ? 16'hffff : 16'((32'd1 << DIM_BITS) - 32'd1);

   // Stage one result
   typedef struct packed {
      logic [19:0] stride;
      logic [15:0] row;
      logic [19:0] xoff;
      logic [63:0] value;
      logic [7:0]  mask;
      logic [3:0]  count;
      logic        fault;
   } pwa_stage_type;

   logic          s1_valid_ff, s1_valid_in;
   pwa_stage_type s1_ff, s1_in;

   logic [15:0] w, h, x, y, xm, ym;
   logic        low_depth, byte_depth, wide_depth;
   logic [2:0]  samples;
   logic [3:0]  bpp;
   logic        bad;
   logic [1:0]  lg;
   logic [2:0]  per_m1, xmod, sh;
   logic [7:0]  bits;
   logic [16:0] lo_stride;
   logic [15:0] lo_xoff;
   logic [19:0] wd_prod, wd_xoff;
   logic [35:0] prod, addr_sum;

   // Mask dimensions and coordinates
   assign w = cfg.image_width & DIM_MASK;
   assign h = cfg.image_height & DIM_MASK;
   assign x = req_data.pixel_x & DIM_MASK;
   assign y = req_data.pixel_y & DIM_MASK;

   // Classify depth and colour kind
   assign low_depth  = (cfg.sample_depth == 5'd1) || (cfg.sample_depth == 5'd2) ||
                       (cfg.sample_depth == 5'd4);
   assign byte_depth = (cfg.sample_depth == 5'd8);
   assign wide_depth = (cfg.sample_depth == 5'd16);

   always_comb begin
      unique case (cfg.colour_kind)
         KIND_GREY:       samples = (low_depth || byte_depth || wide_depth) ? 3'd1 : 3'd0;
         KIND_RGB:        samples = (byte_depth || wide_depth) ? 3'd3 : 3'd0;
         KIND_PALETTE:    samples = (low_depth || byte_depth) ? 3'd1 : 3'd0;
         KIND_GREY_ALPHA: samples = (byte_depth || wide_depth) ? 3'd2 : 3'd0;
         KIND_RGBA:       samples = (byte_depth || wide_depth) ? 3'd4 : 3'd0;
         default:         samples = 3'd0;
      endcase
   end

   assign bpp = wide_depth ? {samples, 1'b0} : {1'b0, samples};
   assign bad = (x >= w) || (y >= h) || (samples == 3'd0) ||
                (!low_depth && (bpp > 4'(MAX_PIXEL_BYTES)));

   // Mirror the coordinate
   assign xm = cfg.mirror_x ? (w - x - 16'd1) : x;
   assign ym = cfg.mirror_y ? (h - y - 16'd1) : y;

   // Sub-byte packing: pixels per byte, bit position and field mask
   assign xmod = xm[2:0] & per_m1;
   always_comb begin
      unique case (cfg.sample_depth)
         5'd1: begin
            lg = 2'd3; per_m1 = 3'd7; bits = 8'h01;
            sh = 3'd7 - xmod;
         end
         5'd2: begin
            lg = 2'd2; per_m1 = 3'd3; bits = 8'h03;
            sh = 3'((3'd3 - xmod) << 1);
         end
         5'd4: begin
            lg = 2'd1; per_m1 = 3'd1; bits = 8'h0f;
            sh = 3'((3'd1 - xmod) << 2);
         end
         default: begin
            lg = 2'd0; per_m1 = 3'd0; bits = 8'h00;
            sh = 3'd0;
         end
      endcase
   end

   assign lo_stride = 17'(({1'b0, w} + {14'd0, per_m1}) >> lg) + 17'd1;
   assign lo_xoff   = xm >> lg;

   // Byte-aligned pixels: stride and column offset scale by bytes per pixel
   assign wd_prod = {4'd0, w} * {16'd0, bpp};
   assign wd_xoff = {4'd0, xm} * {16'd0, bpp};

   always_comb begin
      s1_valid_in  = accept;
      s1_in.row    = ym;
      priority if (bad) begin
         s1_in.stride = '0;
         s1_in.xoff   = '0;
         s1_in.value  = '0;
         s1_in.mask   = '0;
         s1_in.count  = 4'd1;
         s1_in.fault  = 1'b1;
      end else if (low_depth) begin
         s1_in.stride = {3'd0, lo_stride};
         s1_in.xoff   = {4'd0, lo_xoff};
         s1_in.value  = {56'd0, 8'((req_data.pixel_value[7:0] & bits) << sh)};
         s1_in.mask   = 8'(bits << sh);
         s1_in.count  = 4'd1;
         s1_in.fault  = 1'b0;
      end else begin
         s1_in.stride = wd_prod + 20'd1;
         s1_in.xoff   = wd_xoff;
         s1_in.value  = req_data.pixel_value;
         s1_in.mask   = 8'hff;
         s1_in.count  = bpp;
         s1_in.fault  = 1'b0;
      end
   end

   // Hold classified pixel for the address multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff <= s1_in;
   end

   // Row index times stride plus column offset plus filter byte
   assign prod     = {16'd0, s1_ff.stride} * {20'd0, s1_ff.row};
   assign addr_sum = prod + {16'd0, s1_ff.xoff} + 36'd1;

   assign out_valid       = s1_valid_ff;
   assign out_entry.addr  = s1_ff.fault ? '0 : addr_sum[ADDR_BITS-1:0];
   assign out_entry.value = s1_ff.value;
   assign out_entry.mask  = s1_ff.mask;
   assign out_entry.count = s1_ff.count;
   assign out_entry.fault = s1_ff.fault;

endmodule
`default_nettype wire

// ===== design/pwa_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PNG pixel write addresser queue
// Short FIFO of classified pixels between the front and back ends.
// ----------------------------------------------------------------------------
module pwa_queue
   import pwa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire pwa_entry_type wdata,
   input  wire logic          pop,
   output pwa_entry_type      rdata,
   output logic               empty
);

   pwa_entry_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0]     count_ff, count_in;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + QCOUNT_BITS'(push) - QCOUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store pushed entry
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata = entry_ff[rd_ptr_ff];
   assign empty = (count_ff == '0);

endmodule
`default_nettype wire

// ===== design/pwa_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// PNG pixel write addresser back end
// Walks the head pixel byte by byte, most significant byte first, and
// registers one write per cycle onto the result port while the queue has data.
// ----------------------------------------------------------------------------
module pwa_back
   import pwa_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          empty,
   input  wire pwa_entry_type head,
   output logic               pop,
   output logic               rsp_strobe,
   output pwa_rsp_type        rsp_data
);

   logic [2:0]  idx_ff, idx_in;
   logic        strobe_ff, strobe_in;
   pwa_rsp_type rsp_ff, rsp_in;
   logic        last;
   logic [2:0]  sel;

   // Pick the byte for this step
   assign last = ({1'b0, idx_ff} == (head.count - 4'd1));
   assign sel  = 3'(head.count - 4'd1 - {1'b0, idx_ff});
   assign pop  = !empty && last;

   always_comb begin
      strobe_in           = !empty;
      idx_in              = empty ? idx_ff : (last ? 3'd0 : idx_ff + 3'd1);
      rsp_in.byte_address = head.addr + {{(ADDR_BITS-3){1'b0}}, idx_ff};
      rsp_in.write_byte   = head.value[{sel, 3'b000} +: 8];
      rsp_in.write_mask   = head.mask;
      rsp_in.fault        = head.fault;
      rsp_in.last_write   = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         idx_ff    <= idx_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule
`default_nettype wire
